// File: rtl/lrc_time_tag_parser_defines.svh
// Assertion macros for the LRC time tag parser.
`ifndef LRC_TIME_TAG_PARSER_DEFINES_SVH
`define LRC_TIME_TAG_PARSER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LRC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lrc_pkg.sv
`default_nettype none

package lrc_pkg;

	// Line phase of the byte parser
	typedef enum logic [1:0] {
		PH_EXPECT,
		PH_TAG,
		PH_SKIP
	} phase_t;

	// Status of a leading digit run
	typedef enum logic [1:0] {
		RUN_NONE,
		RUN_GOING,
		RUN_DONE,
		RUN_FAIL
	} run_t;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_OPEN    = 8'd91;
	localparam logic [7:0] CH_CLOSE   = 8'd93;
	localparam logic [7:0] CH_COLON   = 8'd58;
	localparam logic [7:0] CH_DOT     = 8'd46;
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_NINE    = 8'd57;

	localparam logic [2:0] MIN_INNER_LEN = 3'd5;
	localparam logic [1:0] FRAC_MAX      = 2'd3;

	localparam logic [31:0] MS_PER_MIN = 32'd60000;
	localparam logic [31:0] MS_PER_SEC = 32'd1000;

	typedef struct packed {
		logic [31:0] value;
		run_t        status;
	} run_state_t;

	// One accepted tag handed from the parser to the time unit
	typedef struct packed {
		logic [31:0] minute;
		logic [31:0] second;
		logic [9:0]  frac_value;
		logic [1:0]  frac_count;
	} tag_fields_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic run_ok(input run_t s);
		return (s == RUN_GOING) || (s == RUN_DONE);
	endfunction

	// Feed one character to a digit run: value*10 + digit, fail on 32-bit overflow
	function automatic run_state_t run_feed(input run_state_t cur, input logic [7:0] c);
		run_state_t  nxt;
		logic [35:0] v;
		nxt = cur;
		v = ({4'b0, cur.value} << 3) + ({4'b0, cur.value} << 1) + {32'b0, c[3:0]};
		if ((cur.status == RUN_GOING) || (cur.status == RUN_NONE)) begin
			if (!is_digit(c)) begin
				nxt.status = (cur.status == RUN_GOING) ? RUN_DONE : RUN_FAIL;
			end else if (v[35:32] != 4'b0) begin
				nxt.status = RUN_FAIL;
			end else begin
				nxt.value  = v[31:0];
				nxt.status = RUN_GOING;
			end
		end
		return nxt;
	endfunction

endpackage

`default_nettype wire

// File: rtl/lrc_if.sv
`default_nettype none

// Text byte channel
interface lrc_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source (output valid, output text_byte, output last_byte, input ready);
	modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

// Timestamp channel
interface lrc_time_if;
	logic        valid;
	logic        ready;
	logic [31:0] time_ms;

	modport source (output valid, output time_ms, input ready);
	modport sink (input valid, input time_ms, output ready);
endinterface

`default_nettype wire

// File: rtl/lrc_front.sv
`default_nettype none

// Byte parser: tracks line phase and the fields of the open tag
module lrc_front (
	input  wire                  clk,
	input  wire                  arst_n,
	lrc_text_if.sink             text_in,
	input  wire                  queue_full,
	output logic                 push_valid,
	output lrc_pkg::tag_fields_t push_data
);

	lrc_pkg::phase_t     phase_q, phase_d;
	logic [2:0]          len_q, len_d;
	logic                colon_q, colon_d;
	logic                dot_q, dot_d;
	lrc_pkg::run_state_t min_q, min_d;
	lrc_pkg::run_state_t sec_q, sec_d;
	logic [1:0]          fcount_q, fcount_d;
	logic [9:0]          fvalue_q, fvalue_d;
	logic                fended_q, fended_d;

	logic        beat;
	logic        tag_ok;
	logic [13:0] fvalue_x10;

	assign text_in.ready = !queue_full;
	assign beat          = text_in.valid && text_in.ready;
	assign fvalue_x10    = ({4'b0, fvalue_q} << 3) + ({4'b0, fvalue_q} << 1)
	                       + {10'b0, text_in.text_byte[3:0]};

	// Next state
	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		colon_d  = colon_q;
		dot_d    = dot_q;
		min_d    = min_q;
		sec_d    = sec_q;
		fcount_d = fcount_q;
		fvalue_d = fvalue_q;
		fended_d = fended_q;
		if (beat) begin
			if (text_in.text_byte == lrc_pkg::CH_NEWLINE) begin
				phase_d = lrc_pkg::PH_EXPECT;
			end else begin
				unique case (phase_q)
					lrc_pkg::PH_EXPECT: begin
						if (text_in.text_byte == lrc_pkg::CH_OPEN) begin
							phase_d  = lrc_pkg::PH_TAG;
							len_d    = 3'd0;
							colon_d  = 1'b0;
							dot_d    = 1'b0;
							min_d    = '{value: 32'd0, status: lrc_pkg::RUN_NONE};
							sec_d    = '{value: 32'd0, status: lrc_pkg::RUN_NONE};
							fcount_d = 2'd0;
							fvalue_d = 10'd0;
							fended_d = 1'b0;
						end else begin
							phase_d = lrc_pkg::PH_SKIP;
						end
					end
					lrc_pkg::PH_TAG: begin
						if (text_in.text_byte == lrc_pkg::CH_CLOSE) begin
							phase_d = tag_ok ? lrc_pkg::PH_EXPECT : lrc_pkg::PH_SKIP;
						end else begin
							if (len_q < lrc_pkg::MIN_INNER_LEN) begin
								len_d = len_q + 3'd1;
							end
							priority if (!colon_q) begin
								if (text_in.text_byte == lrc_pkg::CH_COLON) begin
									colon_d = 1'b1;
								end else begin
									min_d = lrc_pkg::run_feed(min_q, text_in.text_byte);
								end
							end else if (!dot_q) begin
								if (text_in.text_byte == lrc_pkg::CH_DOT) begin
									dot_d = 1'b1;
								end else begin
									sec_d = lrc_pkg::run_feed(sec_q, text_in.text_byte);
								end
							end else if (fcount_q < lrc_pkg::FRAC_MAX) begin
								fcount_d = fcount_q + 2'd1;
								if (!fended_q) begin
									if (lrc_pkg::is_digit(text_in.text_byte)) begin
										fvalue_d = fvalue_x10[9:0];
									end else begin
										fended_d = 1'b1;
									end
								end
							end else begin
								fcount_d = fcount_q;
							end
						end
					end
					default: begin
						phase_d = lrc_pkg::PH_SKIP;
					end
				endcase
				if (text_in.last_byte) begin
					phase_d = lrc_pkg::PH_EXPECT;
				end
			end
		end
	end

	// Outputs: a closing bracket on a well-formed tag pushes it to the queue
	always_comb begin
		tag_ok = (len_q >= lrc_pkg::MIN_INNER_LEN) && colon_q
		         && lrc_pkg::run_ok(min_q.status) && lrc_pkg::run_ok(sec_q.status);
		push_valid = beat && (phase_q == lrc_pkg::PH_TAG)
		             && (text_in.text_byte == lrc_pkg::CH_CLOSE) && tag_ok;
		push_data.minute     = min_q.value;
		push_data.second     = sec_q.value;
		push_data.frac_value = fvalue_q;
		push_data.frac_count = fcount_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lrc_pkg::PH_EXPECT;
			len_q    <= 3'd0;
			colon_q  <= 1'b0;
			dot_q    <= 1'b0;
			min_q    <= '{value: 32'd0, status: lrc_pkg::RUN_NONE};
			sec_q    <= '{value: 32'd0, status: lrc_pkg::RUN_NONE};
			fcount_q <= 2'd0;
			fvalue_q <= 10'd0;
			fended_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			colon_q  <= colon_d;
			dot_q    <= dot_d;
			min_q    <= min_d;
			sec_q    <= sec_d;
			fcount_q <= fcount_d;
			fvalue_q <= fvalue_d;
			fended_q <= fended_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/lrc_queue.sv
`default_nettype none

// Small FIFO of parsed tags between parser and time unit
module lrc_queue #(
	parameter int DEPTH = 4
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push_valid,
	input  lrc_pkg::tag_fields_t push_data,
	output logic                 full,
	input  wire                  pop,
	output logic                 pop_valid,
	output lrc_pkg::tag_fields_t pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	lrc_pkg::tag_fields_t entry_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push, do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && pop_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/lrc_back.sv
`default_nettype none

// Time unit: products in stage 1, sum into the output register in stage 2
module lrc_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  pop_valid,
	input  lrc_pkg::tag_fields_t pop_data,
	output logic                 pop,
	lrc_time_if.source           time_out
);

	logic        valid_s1, valid_s2;
	logic [31:0] min_ms_s1, sec_ms_s1;
	logic [16:0] frac_ms_s1;
	logic [31:0] time_s2;

	logic        adv_s1, adv_s2;
	logic [31:0] min_ms, sec_ms;
	logic [16:0] frac_ms;

	assign adv_s2 = !valid_s2 || time_out.ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop    = pop_valid && adv_s1;

	// Products, kept modulo 2^32
	assign min_ms = pop_data.minute * lrc_pkg::MS_PER_MIN;
	assign sec_ms = pop_data.second * lrc_pkg::MS_PER_SEC;

	// Fraction scaled by its character count
	always_comb begin
		unique case (pop_data.frac_count)
			2'd0:    frac_ms = 17'd0;
			2'd1:    frac_ms = {7'b0, pop_data.frac_value} * 17'd100;
			2'd2:    frac_ms = {7'b0, pop_data.frac_value} * 17'd10;
			default: frac_ms = {7'b0, pop_data.frac_value};
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pop_valid) begin
			min_ms_s1  <= min_ms;
			sec_ms_s1  <= sec_ms;
			frac_ms_s1 <= frac_ms;
		end
		if (adv_s2 && valid_s1) begin
			time_s2 <= min_ms_s1 + sec_ms_s1 + {15'b0, frac_ms_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= pop_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign time_out.valid   = valid_s2;
	assign time_out.time_ms = time_s2;

endmodule

`default_nettype wire

// File: rtl/lrc_time_tag_parser.sv
// Takes one text byte per cycle; ready drops only while the tag queue is full.
// A good tag's closing bracket, once accepted, goes into the queue, then through
// the registered multiply and add of the time unit to time_out. Throughput: one
// byte per cycle unless the queue is full, a timestamp per cycle when not held.
// Reset (arst_n low, asynchronous) returns the parser to line start and empties
// the queue and the time pipeline.
`default_nettype none

module lrc_time_tag_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	lrc_text_if.sink   text_in,
	lrc_time_if.source time_out
);

	logic                 push_valid, queue_full, pop, pop_valid;
	lrc_pkg::tag_fields_t push_data, pop_data;

	lrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_in    (text_in),
		.queue_full (queue_full),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	lrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (queue_full),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data)
	);

	lrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.time_out  (time_out)
	);

endmodule

`default_nettype wire

// File: rtl/lrc_checker.sv
`default_nettype none

`include "lrc_time_tag_parser_defines.svh"

module lrc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [31:0] out_time_ms
);

	// A stalled timestamp beat holds
	`LRC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_time_ms), "stalled timestamp changed")

	// Input back-pressure only comes from a backed-up output
	`LRC_ASSERT_SAME(a_stall_has_cause, clk, arst_n, !in_ready, out_valid, "input stalled with no pending timestamp")

	// The queue fills only during a cycle when the output was held off
	`LRC_ASSERT_SAME(a_fill_on_stall, clk, arst_n, $fell(in_ready), $past(out_valid && !out_ready), "queue filled while output flowing")

endmodule

bind lrc_time_tag_parser lrc_checker u_lrc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (text_in.ready),
	.out_valid   (time_out.valid),
	.out_ready   (time_out.ready),
	.out_time_ms (time_out.time_ms)
);

`default_nettype wire

// File: dv/tb_lrc_time_tag_parser.sv
`timescale 1ns / 1ps

module tb_lrc_time_tag_parser;

	localparam logic [7:0] CH_CR       = 8'd13;
	localparam int         TOTAL_BYTES = 1600;
	localparam int         HOLD_CYCLES = 250;
	localparam int         CALM_FROM   = 1300;
	localparam int         CALM_TO     = 1800;
	localparam int         MAX_PRINTS  = 200;

	// One beat of lyric text
	typedef struct {
		logic [7:0] ch;
		bit         last;
	} text_beat_t;

	// Fields gathered while inside one bracketed tag
	typedef struct {
		logic [2:0]    inner_len;
		bit            has_colon;
		bit            has_dot;
		logic [31:0]   min_val;
		lrc_pkg::run_t min_st;
		logic [31:0]   sec_val;
		lrc_pkg::run_t sec_st;
		logic [1:0]    frac_cnt;
		logic [9:0]    frac_acc;
		bit            frac_stop;
	} tag_acc_t;

	logic clk;
	logic arst_n;

	lrc_text_if text_ch ();
	lrc_time_if time_ch ();

	lrc_time_tag_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_ch),
		.time_out(time_ch)
	);

	text_beat_t  beats_due[$];
	text_beat_t  on_wire;
	logic [31:0] tag_times_due[$];
	logic [31:0] want_ms;

	lrc_pkg::phase_t line_st = lrc_pkg::PH_EXPECT;
	tag_acc_t        cur_tag;

	int cyc        = 0;
	int bytes_sent = 0;
	int times_seen = 0;
	int hold_left  = 0;
	int holds_done = 0;
	int err_cnt    = 0;
	int lines_made = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Timeout: %0d timestamps still pending after %0d text bytes",
			tag_times_due.size(), bytes_sent);
		$display("Some tests failed");
		$finish;
	end

	task automatic report_error(input string msg);
		if (err_cnt < MAX_PRINTS)
			$display("ERROR @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	function automatic bit idle_now();
		if (cyc >= CALM_FROM && cyc < CALM_TO)
			return 1'b0;
		return $urandom_range(0, 99) < 12;
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return (c >= lrc_pkg::CH_ZERO) && (c <= lrc_pkg::CH_NINE);
	endfunction

	function automatic bit run_good(input lrc_pkg::run_t st);
		return (st == lrc_pkg::RUN_GOING) || (st == lrc_pkg::RUN_DONE);
	endfunction

	function automatic tag_acc_t empty_tag();
		tag_acc_t t;
		t.inner_len = '0;
		t.has_colon = 1'b0;
		t.has_dot   = 1'b0;
		t.min_val   = '0;
		t.min_st    = lrc_pkg::RUN_NONE;
		t.sec_val   = '0;
		t.sec_st    = lrc_pkg::RUN_NONE;
		t.frac_cnt  = '0;
		t.frac_acc  = '0;
		t.frac_stop = 1'b0;
		return t;
	endfunction

	// Leading digit run: stops at the first non-digit, fails if empty or past 32 bits
	task automatic feed_digit(inout logic [31:0] val, inout lrc_pkg::run_t st,
			input logic [7:0] c);
		logic [35:0] v;
		v = {4'b0, val} * 36'd10 + {28'b0, c - lrc_pkg::CH_ZERO};
		if (st == lrc_pkg::RUN_DONE || st == lrc_pkg::RUN_FAIL)
			return;
		if (!is_num(c)) begin
			st = (st == lrc_pkg::RUN_GOING) ? lrc_pkg::RUN_DONE : lrc_pkg::RUN_FAIL;
		end else if (v[35:32] != 4'b0) begin
			st = lrc_pkg::RUN_FAIL;
		end else begin
			val = v[31:0];
			st  = lrc_pkg::RUN_GOING;
		end
	endtask

	task automatic take_tag_char(input logic [7:0] c);
		if (cur_tag.inner_len < lrc_pkg::MIN_INNER_LEN)
			cur_tag.inner_len++;
		if (!cur_tag.has_colon) begin
			if (c == lrc_pkg::CH_COLON)
				cur_tag.has_colon = 1'b1;
			else
				feed_digit(cur_tag.min_val, cur_tag.min_st, c);
		end else if (!cur_tag.has_dot) begin
			if (c == lrc_pkg::CH_DOT)
				cur_tag.has_dot = 1'b1;
			else
				feed_digit(cur_tag.sec_val, cur_tag.sec_st, c);
		end else if (cur_tag.frac_cnt < lrc_pkg::FRAC_MAX) begin
			cur_tag.frac_cnt++;
			if (!cur_tag.frac_stop) begin
				if (is_num(c))
					cur_tag.frac_acc = cur_tag.frac_acc * 10'd10
						+ {2'b0, c - lrc_pkg::CH_ZERO};
				else
					cur_tag.frac_stop = 1'b1;
			end
		end
	endtask

	// Line parser: queues the millisecond time of every good tag
	task automatic parse_text_byte(input logic [7:0] c, input bit last);
		logic [63:0] frac_ms;
		logic [63:0] total;
		if (c == lrc_pkg::CH_NEWLINE) begin
			line_st = lrc_pkg::PH_EXPECT;
			return;
		end
		case (line_st)
			lrc_pkg::PH_EXPECT: begin
				if (c == lrc_pkg::CH_OPEN) begin
					cur_tag = empty_tag();
					line_st = lrc_pkg::PH_TAG;
				end else begin
					line_st = lrc_pkg::PH_SKIP;
				end
			end
			lrc_pkg::PH_TAG: begin
				if (c == lrc_pkg::CH_CLOSE) begin
					if (cur_tag.inner_len >= lrc_pkg::MIN_INNER_LEN && cur_tag.has_colon &&
							run_good(cur_tag.min_st) && run_good(cur_tag.sec_st)) begin
						// fraction scaled by the number of characters taken
						case (cur_tag.frac_cnt)
							2'd1:    frac_ms = {54'b0, cur_tag.frac_acc} * 64'd100;
							2'd2:    frac_ms = {54'b0, cur_tag.frac_acc} * 64'd10;
							2'd3:    frac_ms = {54'b0, cur_tag.frac_acc};
							default: frac_ms = '0;
						endcase
						total = {32'b0, cur_tag.min_val} * {32'b0, lrc_pkg::MS_PER_MIN} +
							{32'b0, cur_tag.sec_val} * {32'b0, lrc_pkg::MS_PER_SEC} + frac_ms;
						tag_times_due.insert(tag_times_due.size(), total[31:0]);
						line_st = lrc_pkg::PH_EXPECT;
					end else begin
						line_st = lrc_pkg::PH_SKIP;
					end
				end else begin
					take_tag_char(c);
				end
			end
			default: line_st = lrc_pkg::PH_SKIP;
		endcase
		if (last)
			line_st = lrc_pkg::PH_EXPECT;
	endtask

	// Stimulus builders
	task automatic add_byte(input logic [7:0] c, input bit last);
		text_beat_t b;
		b.ch   = c;
		b.last = last;
		beats_due.insert(beats_due.size(), b);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], 1'b0);
	endtask

	task automatic end_line(input bit last);
		add_byte(lrc_pkg::CH_NEWLINE, last);
		lines_made++;
	endtask

	task automatic mark_last();
		beats_due[$].last = 1'b1;
		lines_made++;
	endtask

	task automatic add_digits(input int n);
		if (n == 10 && $urandom_range(0, 2) == 0) begin
			// close to the 32-bit limit
			add_text("42949672");
			n = 2;
		end
		for (int i = 0; i < n; i++)
			add_byte(lrc_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
	endtask

	function automatic int run_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return 0;
		if (r < 14)
			return $urandom_range(9, 11);
		return $urandom_range(1, 2);
	endfunction

	task automatic add_random_tag();
		int n;
		add_byte(lrc_pkg::CH_OPEN, 1'b0);
		add_digits(run_len());
		if ($urandom_range(0, 19) == 0)
			add_byte(8'($urandom_range(97, 122)), 1'b0);
		if ($urandom_range(0, 19) != 0)
			add_byte(lrc_pkg::CH_COLON, 1'b0);
		add_digits(run_len());
		if ($urandom_range(0, 4) != 0) begin
			add_byte(lrc_pkg::CH_DOT, 1'b0);
			n = $urandom_range(0, 4);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) != 0)
					add_byte(lrc_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
				else
					add_byte(8'($urandom_range(32, 126)), 1'b0);
			end
		end
		if ($urandom_range(0, 29) == 0)
			add_byte(8'($urandom_range(0, 255)), 1'b0);
		if ($urandom_range(0, 19) != 0)
			add_byte(lrc_pkg::CH_CLOSE, 1'b0);
	endtask

	task automatic add_random_line();
		string alpha;
		int    kind;
		int    n;
		alpha = "0123456789:.[]";
		kind  = $urandom_range(0, 99);
		if (kind < 75) begin
			// line of tags, some of them malformed, then lyric text
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++)
				add_random_tag();
			n = $urandom_range(0, 6);
			for (int i = 0; i < n; i++)
				add_byte(8'($urandom_range(32, 126)), 1'b0);
		end else if (kind < 88) begin
			// raw noise over the full byte range
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				add_byte(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			// broken tag made of tag characters
			add_byte(lrc_pkg::CH_OPEN, 1'b0);
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				add_byte(alpha[$urandom_range(0, alpha.len() - 1)], 1'b0);
		end
		if ($urandom_range(0, 99) < 8)
			mark_last();
		else
			end_line($urandom_range(0, 19) == 0);
	endtask

	always @(posedge clk)
		cyc <= cyc + 1;

	// Long output hold-off so the tag queue fills and the input stalls
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && bytes_sent >= 400 + holds_done * 700) begin
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// Text driver
	always @(posedge clk) begin
		if (!arst_n) begin
			text_ch.valid <= 1'b0;
		end else begin
			if (text_ch.valid && text_ch.ready) begin
				parse_text_byte(on_wire.ch, on_wire.last);
				bytes_sent <= bytes_sent + 1;
			end
			if (!text_ch.valid || text_ch.ready) begin
				if (beats_due.size() != 0 && !idle_now()) begin
					on_wire = beats_due.pop_front();
					text_ch.valid     <= 1'b1;
					text_ch.text_byte <= on_wire.ch;
					text_ch.last_byte <= on_wire.last;
				end else begin
					text_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Timestamp monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			time_ch.ready <= 1'b0;
		end else begin
			if (time_ch.valid && time_ch.ready) begin
				times_seen++;
				if (tag_times_due.size() == 0) begin
					report_error($sformatf("unexpected timestamp %0d", time_ch.time_ms));
				end else begin
					want_ms = tag_times_due.pop_front();
					if (time_ch.time_ms !== want_ms)
						report_error($sformatf("time_ms %0d, expected %0d",
							time_ch.time_ms, want_ms));
				end
			end
			time_ch.ready <= (hold_left == 0) && !idle_now();
		end
	end

	initial begin
		arst_n            = 1'b0;
		text_ch.valid     = 1'b0;
		text_ch.text_byte = '0;
		text_ch.last_byte = 1'b0;
		time_ch.ready     = 1'b0;
		cur_tag           = empty_tag();

		// Directed lines
		add_text("[00:00.000]");                    end_line(1'b0);
		add_text("[99:59.999]abc");                 end_line(1'b0);
		add_text("[4294967295:4294967295.999]");    end_line(1'b0);
		add_text("[4294967296:00]");                end_line(1'b0);
		// fraction of one, two, three (with a non-digit) and no characters
		add_text("[01:02.5][01:02.50][1:2.5x7][01:02.]"); end_line(1'b0);
		add_text("[1:2]x");                         end_line(1'b0);
		add_text("[12345]");                        end_line(1'b0);
		add_text("[01:02.03");                      end_line(1'b0);
		// nested bracket is an ordinary character
		add_text("[01:02.[5][[1:02.03]");           end_line(1'b0);
		add_text("[01:02.03]");
		add_byte(CH_CR, 1'b0);                      end_line(1'b0);
		add_byte(CH_CR, 1'b0);
		add_text("[01:00]");                        end_line(1'b0);
		end_line(1'b0);
		add_text("[00:01.00][00:02.00][00:03]la la"); end_line(1'b1);
		add_text("[ab:cd][01:00.00]");              end_line(1'b0);
		add_text("[12a:30.5][:30.50]");             end_line(1'b0);
		add_text("[01:.50]");                       end_line(1'b0);
		add_text("[00:05.00");
		add_byte(lrc_pkg::CH_CLOSE, 1'b1);
		add_text("[00:0");                          mark_last();
		add_text("7:00]");                          end_line(1'b0);
		add_text("[0");
		add_byte(8'hFF, 1'b0);
		add_text(":00]");                           end_line(1'b0);
		add_text("[01:02.");
		add_byte(8'h00, 1'b0);
		add_text("9]");                             end_line(1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b1);
		add_text("]");                              end_line(1'b0);

		// Random lines up to the byte budget
		while (beats_due.size() < TOTAL_BYTES)
			add_random_line();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_due.size() != 0 || text_ch.valid)
			@(posedge clk);
		while (tag_times_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d text bytes in %0d lines; checked %0d timestamps", bytes_sent,
			lines_made, times_seen);
		$display("Output held off %0d times for %0d cycles each", holds_done, HOLD_CYCLES);
		if (err_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
